### rtl/cpos_pkg.sv
// ----------------------------------------------------------------------------
// cpos_pkg
// Shared types, codes and constants of the cassette positioner.
// ----------------------------------------------------------------------------
package cpos_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
    localparam int CELL_W    = 6;
    localparam int STEP_W    = 7;
    localparam int TICK_W    = 16;
    localparam int PROD_W    = CELL_W + STEP_W;
    localparam int CNT_W     = $clog2(SLOT_W + 1);

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam logic REG_CELL_STEP = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    typedef enum logic [2:0] {
        OP_GOTO    = 3'd0,
        OP_TICK    = 3'd1,
        OP_SNS_ON  = 3'd2,
        OP_SNS_OFF = 3'd3,
        OP_STOPPED = 3'd4,
        OP_KEY     = 3'd5,
        OP_FORGET  = 3'd6,
        OP_UNUSED  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        EV_ZERO     = 2'd0,
        EV_CELL     = 2'd1,
        EV_STOP_KEY = 2'd2,
        EV_OTHER    = 2'd3
    } t_evt;

    typedef enum logic [2:0] {
        MC_NONE  = 3'd0,
        MC_FWD   = 3'd1,
        MC_BACK  = 3'd2,
        MC_DECEL = 3'd3,
        MC_STOP  = 3'd4
    } t_motor;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_DONE    = 3'd1,
        ST_TIMEOUT = 3'd2,
        ST_BREAK   = 3'd3,
        ST_REJECT  = 3'd4
    } t_status;

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_ZERO_ON   = 6'b000010,
        PH_ZERO_OFF  = 6'b000100,
        PH_CELL_OFF  = 6'b001000,
        PH_CELL_ON   = 6'b010000,
        PH_MOTOR_OFF = 6'b100000
    } t_phase;

    typedef enum logic [3:0] {
        CS_IDLE  = 4'b0001,
        CS_APPLY = 4'b0010,
        CS_DIV   = 4'b0100,
        CS_OUT   = 4'b1000
    } t_cstate;

    typedef struct packed {
        logic load;
        logic apply;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

### rtl/cpos_ctrl.sv
// ----------------------------------------------------------------------------
// cpos_ctrl
// Sequencer: latch a transfer, apply it, run the divider, load the result.
// ----------------------------------------------------------------------------
module cpos_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  cpos_pkg::t_sts i_sts,
    output cpos_pkg::t_cmd o_cmd
);
    import cpos_pkg::*;

    t_cstate r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != CS_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        n_out_valid    = r_out_valid && i_out_stall;
        unique case (r_state)
            CS_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = CS_APPLY;
                end
            end
            CS_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = CS_DIV;
            end
            CS_DIV: begin
                if (i_sts.div_done) begin
                    n_state = CS_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            CS_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_accept_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == CS_APPLY))
        else $error("accepted transfer not applied next cycle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("pending result overwritten");

    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CS_DIV && i_sts.div_done) |=> (r_state == CS_OUT))
        else $error("divider finish not followed by result load");

endmodule

### rtl/cpos_dpath.sv
// ----------------------------------------------------------------------------
// cpos_dpath
// Positioner state, event update and restoring divider for the cell index.
// ----------------------------------------------------------------------------
module cpos_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpos_pkg::t_cmd                i_cmd,
    output cpos_pkg::t_sts                o_sts,
    input  logic [cpos_pkg::STEP_W-1:0]   i_cell_step,
    input  logic [cpos_pkg::TICK_W-1:0]   i_timeout_ticks,
    input  logic [2:0]                    i_op,
    input  logic [5:0]                    i_target_cell,
    input  logic [1:0]                    i_event_code,
    input  logic                          i_zero_sensor_level,
    input  logic                          i_cell_sensor_level,
    output logic [2:0]                    o_motor_cmd,
    output logic [2:0]                    o_status,
    output logic                          o_position_known,
    output logic [5:0]                    o_cell_index
);
    import cpos_pkg::*;

    // latched transfer
    t_op               r_op;
    logic [CELL_W-1:0] r_cell;
    t_evt              r_evt;
    logic              r_zero_lit;
    logic              r_cell_lit;

    // positioner state
    t_phase            r_phase, n_phase;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_valid, n_valid;
    logic [SLOT_W-1:0] r_target, n_target;
    logic              r_fwd, n_fwd;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;

    // pending result
    t_motor            r_motor, n_motor;
    t_status           r_status, n_status;

    // divider
    logic [STEP_W-1:0] r_rem;
    logic [SLOT_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W:0]   div_shift;
    logic              div_ge;

    logic [STEP_W-1:0] eff_step;
    logic [PROD_W-1:0] dst;
    logic [SLOT_W-1:0] dst_slot;
    logic              dst_bad;
    logic              stat_set;
    logic [CELL_W+SLOT_W-1:0] quo_ext;

    assign eff_step = (i_cell_step == '0) ? STEP_W'(1) : i_cell_step;
    assign dst      = PROD_W'(r_cell) * PROD_W'(eff_step);
    assign dst_slot = dst[SLOT_W-1:0];
    assign dst_bad  = (dst >= PROD_W'(NUM_SLOTS)) || (r_valid && (dst_slot == r_slot));

    always_comb begin
        n_phase   = r_phase;
        n_slot    = r_slot;
        n_valid   = r_valid;
        n_target  = r_target;
        n_fwd     = r_fwd;
        n_elapsed = r_elapsed;
        n_motor   = MC_NONE;
        n_status  = ST_BUSY;
        stat_set  = 1'b0;
        unique case (r_op)
            OP_GOTO: begin
                if (dst_bad) begin
                    n_status = ST_REJECT;
                    stat_set = 1'b1;
                end else begin
                    n_target = dst_slot;
                    if (!r_valid || dst_slot == '0) begin
                        n_fwd   = !r_zero_lit;
                        n_phase = r_zero_lit ? PH_ZERO_OFF : PH_ZERO_ON;
                    end else begin
                        n_phase = r_cell_lit ? PH_CELL_OFF : PH_CELL_ON;
                        n_fwd   = (dst_slot > r_slot);
                    end
                    n_motor   = n_fwd ? MC_FWD : MC_BACK;
                    n_elapsed = '0;
                end
            end
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (r_elapsed != TICK_MAX) begin
                        n_elapsed = r_elapsed + TICK_W'(1);
                    end
                    if (n_elapsed >= i_timeout_ticks) begin
                        n_motor  = MC_STOP;
                        n_valid  = 1'b0;
                        n_slot   = '0;
                        n_phase  = PH_IDLE;
                        n_status = ST_TIMEOUT;
                        stat_set = 1'b1;
                    end
                end
            end
            OP_SNS_ON: begin
                if (r_evt == EV_ZERO && r_phase == PH_ZERO_ON) begin
                    n_elapsed = '0;
                    n_motor   = MC_DECEL;
                end else if (r_evt == EV_CELL && r_phase == PH_CELL_ON) begin
                    n_phase = PH_MOTOR_OFF;
                    if (r_fwd) begin
                        if (r_slot < SLOT_W'(NUM_SLOTS - 1)) begin
                            n_slot = r_slot + SLOT_W'(1);
                        end
                        if (n_slot >= r_target) begin
                            n_motor = MC_DECEL;
                        end else begin
                            n_phase = PH_CELL_OFF;
                        end
                    end else begin
                        if (r_slot != '0) begin
                            n_slot = r_slot - SLOT_W'(1);
                        end
                        if (n_slot <= r_target) begin
                            n_motor = MC_DECEL;
                        end else begin
                            n_phase = PH_CELL_OFF;
                        end
                    end
                end
            end
            OP_SNS_OFF: begin
                if (r_evt == EV_CELL && r_phase == PH_CELL_OFF) begin
                    n_phase = PH_CELL_ON;
                end else if (r_evt == EV_ZERO && r_phase == PH_ZERO_OFF) begin
                    n_elapsed = '0;
                    n_motor   = MC_DECEL;
                end
            end
            OP_STOPPED: begin
                if (r_phase == PH_ZERO_ON) begin
                    n_slot  = '0;
                    n_valid = 1'b1;
                    if (r_target != '0) begin
                        n_phase   = r_cell_lit ? PH_CELL_OFF : PH_CELL_ON;
                        n_fwd     = 1'b1;
                        n_motor   = MC_FWD;
                        n_elapsed = '0;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end else if (r_phase == PH_ZERO_OFF) begin
                    n_fwd     = 1'b1;
                    n_phase   = PH_ZERO_ON;
                    n_motor   = MC_FWD;
                    n_elapsed = '0;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            OP_KEY: begin
                if (r_evt == EV_STOP_KEY) begin
                    n_motor  = MC_STOP;
                    n_valid  = 1'b0;
                    n_slot   = '0;
                    n_phase  = PH_IDLE;
                    n_status = ST_BREAK;
                    stat_set = 1'b1;
                end
            end
            OP_FORGET: begin
                n_valid = 1'b0;
                n_slot  = '0;
            end
            default: begin
            end
        endcase
        if (!stat_set) begin
            n_status = (n_phase == PH_IDLE) ? ST_DONE : ST_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_slot    <= '0;
            r_valid   <= 1'b0;
            r_target  <= '0;
            r_fwd     <= 1'b1;
            r_elapsed <= '0;
        end else if (i_cmd.apply) begin
            r_phase   <= n_phase;
            r_slot    <= n_slot;
            r_valid   <= n_valid;
            r_target  <= n_target;
            r_fwd     <= n_fwd;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_op'(i_op);
            r_cell     <= i_target_cell;
            r_evt      <= t_evt'(i_event_code);
            r_zero_lit <= i_zero_sensor_level;
            r_cell_lit <= i_cell_sensor_level;
        end
        if (i_cmd.apply) begin
            r_motor  <= n_motor;
            r_status <= n_status;
        end
    end

    // restoring division of the slot by the effective cell step
    assign div_shift = {r_rem, r_quo[SLOT_W-1]};
    assign div_ge    = (div_shift >= {1'b0, eff_step});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.apply) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_rem <= '0;
            r_quo <= n_slot;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? STEP_W'(div_shift - {1'b0, eff_step}) : div_shift[STEP_W-1:0];
            r_quo <= SLOT_W'({r_quo, div_ge});
        end
    end

    assign o_sts.div_done = (r_cnt == CNT_W'(SLOT_W));
    assign quo_ext        = {{CELL_W{1'b0}}, r_quo};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_motor_cmd      <= r_motor;
            o_status         <= r_status;
            o_position_known <= r_valid;
            o_cell_index     <= r_valid ? quo_ext[CELL_W-1:0] : '0;
        end
    end

endmodule

### rtl/cassette_positioner_fsm.sv
// ----------------------------------------------------------------------------
// cassette_positioner_fsm
// Rotary cassette positioner: event sequencer with register port.
// ----------------------------------------------------------------------------
// Each accepted event yields exactly one result transfer. An event is latched,
// applied to the positioner state in the next cycle, and the cell index is
// then formed by a restoring divider that retires one quotient bit per cycle
// (log2 of the slot count, six bits for 64 slots). The input stalls from
// acceptance until the result register is loaded, which waits for a free
// output, so the block takes no new event before that result is loaded.
// The result register lets a new event enter while a result waits. Register 0
// (byte address 0) is the cell step, register 1 (byte address 4) the timeout
// in ticks; write them only while no event is in flight.
// ----------------------------------------------------------------------------
module cassette_positioner_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [5:0]  i_target_cell,
    input  logic [1:0]  i_event_code,
    input  logic        i_zero_sensor_level,
    input  logic        i_cell_sensor_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_motor_cmd,
    output logic [2:0]  o_status,
    output logic        o_position_known,
    output logic [5:0]  o_cell_index,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cpos_pkg::*;

    logic [STEP_W-1:0] r_cell_step;
    logic [TICK_W-1:0] r_timeout;
    logic              cfg_wr;
    t_cmd              cmd;
    t_sts              sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_step <= STEP_W'(1);
            r_timeout   <= TICK_W'(5000);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_CELL_STEP) begin
                r_cell_step <= pwdata[STEP_W-1:0];
            end else begin
                r_timeout <= pwdata[TICK_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_TIMEOUT) begin
            prdata = {{(32-TICK_W){1'b0}}, r_timeout};
        end else begin
            prdata = {{(32-STEP_W){1'b0}}, r_cell_step};
        end
    end

    cpos_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cpos_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_cell_step         (r_cell_step),
        .i_timeout_ticks     (r_timeout),
        .i_op                (i_op),
        .i_target_cell       (i_target_cell),
        .i_event_code        (i_event_code),
        .i_zero_sensor_level (i_zero_sensor_level),
        .i_cell_sensor_level (i_cell_sensor_level),
        .o_motor_cmd         (o_motor_cmd),
        .o_status            (o_status),
        .o_position_known    (o_position_known),
        .o_cell_index        (o_cell_index)
    );

endmodule

### test/cassette_positioner_fsm_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cassette_positioner_fsm_test
// Self-checking bench for the cassette positioner. Events are driven through
// the input channel and each one is run through a behavioural positioner kept
// in the bench. The result that this gives is queued and compared field by
// field with the transfer the block returns. Register checks come first, then directed homing,
// stepping, limit and break sequences, then well-formed random moves mixed with
// noise, under several register settings, idling patterns and a long output
// hold-off.
// ----------------------------------------------------------------------------
module cassette_positioner_fsm_test;

    import cpos_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_EVENTS  = 180;

    typedef struct packed {
        t_op         op;
        logic [5:0]  tgt_cell;
        t_evt        code;
        logic        zero_lit;
        logic        cell_lit;
    } t_cassette_event;

    typedef struct packed {
        t_motor      motor;
        t_status     status;
        logic        known;
        logic [5:0]  cell_index;
    } t_cassette_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_op;
    logic [5:0]  i_target_cell;
    logic [1:0]  i_event_code;
    logic        i_zero_sensor_level;
    logic        i_cell_sensor_level;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_motor_cmd;
    logic [2:0]  o_status;
    logic        o_position_known;
    logic [5:0]  o_cell_index;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // positioner state as the bench sees it
    t_phase             cur_phase;
    logic [SLOT_W-1:0]  cur_slot;
    logic               slot_known;
    logic [SLOT_W-1:0]  goal_slot;
    logic               heading_fwd;
    logic [TICK_W-1:0]  ticks_since;
    logic [STEP_W-1:0]  step_reg;
    logic [TICK_W-1:0]  timeout_reg;
    logic               braking;

    t_cassette_result expected_results[$];
    int fault_count;
    int cycle_count;
    int send_gap_pct;
    int recv_stall_pct;
    int hold_off_left;

    cassette_positioner_fsm u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_op                (i_op),
        .i_target_cell       (i_target_cell),
        .i_event_code        (i_event_code),
        .i_zero_sensor_level (i_zero_sensor_level),
        .i_cell_sensor_level (i_cell_sensor_level),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_motor_cmd         (o_motor_cmd),
        .o_status            (o_status),
        .o_position_known    (o_position_known),
        .o_cell_index        (o_cell_index),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run limit reached", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    // output stall: long hold-off first, else random
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_stall <= 1'b1;
            hold_off_left = hold_off_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_cassette_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected transfer: motor %0d status %0d known %0d cell %0d",
                         $time, o_motor_cmd, o_status, o_position_known, o_cell_index);
                fault_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_motor_cmd !== want.motor) begin
                    $display("%0t: motor_cmd expected %0d actual %0d",
                             $time, want.motor, o_motor_cmd);
                    fault_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    fault_count++;
                end
                if (o_position_known !== want.known) begin
                    $display("%0t: position_known expected %0d actual %0d",
                             $time, want.known, o_position_known);
                    fault_count++;
                end
                if (o_cell_index !== want.cell_index) begin
                    $display("%0t: cell_index expected %0d actual %0d",
                             $time, want.cell_index, o_cell_index);
                    fault_count++;
                end
            end
        end
    end

    function automatic t_cassette_event cassette_event(t_op op, logic [5:0] tgt_cell,
                                                       t_evt code, logic zero_lit,
                                                       logic cell_lit);
        t_cassette_event ev;
        ev.op       = op;
        ev.tgt_cell = tgt_cell;
        ev.code     = code;
        ev.zero_lit = zero_lit;
        ev.cell_lit = cell_lit;
        return ev;
    endfunction

    function automatic logic [STEP_W-1:0] effective_step();
        return (step_reg == 0) ? 7'd1 : step_reg;
    endfunction

    function automatic void lose_position();
        slot_known = 1'b0;
        cur_slot   = '0;
    endfunction

    function automatic t_cassette_result advance_positioner(t_cassette_event ev);
        t_cassette_result  res;
        logic [PROD_W-1:0] dest;
        logic [STEP_W-1:0] step;
        logic              status_set;
        step       = effective_step();
        res.motor  = MC_NONE;
        res.status = ST_BUSY;
        status_set = 1'b0;
        case (ev.op)
            OP_GOTO: begin
                dest = PROD_W'(ev.tgt_cell) * PROD_W'(step);
                if (dest >= NUM_SLOTS || (slot_known && dest == PROD_W'(cur_slot))) begin
                    res.status = ST_REJECT;
                    status_set = 1'b1;
                end else begin
                    goal_slot = dest[SLOT_W-1:0];
                    if (!slot_known || dest == 0) begin
                        heading_fwd = !ev.zero_lit;
                        cur_phase   = ev.zero_lit ? PH_ZERO_OFF : PH_ZERO_ON;
                    end else begin
                        cur_phase   = ev.cell_lit ? PH_CELL_OFF : PH_CELL_ON;
                        heading_fwd = goal_slot > cur_slot;
                    end
                    res.motor   = heading_fwd ? MC_FWD : MC_BACK;
                    ticks_since = '0;
                end
            end
            OP_TICK: begin
                if (cur_phase != PH_IDLE) begin
                    if (ticks_since != TICK_MAX) ticks_since++;
                    if (ticks_since >= timeout_reg) begin
                        res.motor = MC_STOP;
                        lose_position();
                        cur_phase  = PH_IDLE;
                        res.status = ST_TIMEOUT;
                        status_set = 1'b1;
                    end
                end
            end
            OP_SNS_ON: begin
                if (ev.code == EV_ZERO && cur_phase == PH_ZERO_ON) begin
                    ticks_since = '0;
                    res.motor   = MC_DECEL;
                end else if (ev.code == EV_CELL && cur_phase == PH_CELL_ON) begin
                    cur_phase = PH_MOTOR_OFF;
                    if (heading_fwd) begin
                        if (cur_slot != NUM_SLOTS - 1) cur_slot++;
                        if (cur_slot >= goal_slot) res.motor = MC_DECEL;
                        else cur_phase = PH_CELL_OFF;
                    end else begin
                        if (cur_slot != 0) cur_slot--;
                        if (cur_slot <= goal_slot) res.motor = MC_DECEL;
                        else cur_phase = PH_CELL_OFF;
                    end
                end
            end
            OP_SNS_OFF: begin
                if (ev.code == EV_CELL && cur_phase == PH_CELL_OFF) begin
                    cur_phase = PH_CELL_ON;
                end else if (ev.code == EV_ZERO && cur_phase == PH_ZERO_OFF) begin
                    ticks_since = '0;
                    res.motor   = MC_DECEL;
                end
            end
            OP_STOPPED: begin
                if (cur_phase == PH_ZERO_ON) begin
                    cur_slot   = '0;
                    slot_known = 1'b1;
                    if (goal_slot != 0) begin
                        cur_phase   = ev.cell_lit ? PH_CELL_OFF : PH_CELL_ON;
                        heading_fwd = 1'b1;
                        res.motor   = MC_FWD;
                        ticks_since = '0;
                    end else begin
                        cur_phase = PH_IDLE;
                    end
                end else if (cur_phase == PH_ZERO_OFF) begin
                    heading_fwd = 1'b1;
                    cur_phase   = PH_ZERO_ON;
                    res.motor   = MC_FWD;
                    ticks_since = '0;
                end else begin
                    cur_phase = PH_IDLE;
                end
            end
            OP_KEY: begin
                if (ev.code == EV_STOP_KEY) begin
                    res.motor = MC_STOP;
                    lose_position();
                    cur_phase  = PH_IDLE;
                    res.status = ST_BREAK;
                    status_set = 1'b1;
                end
            end
            OP_FORGET: lose_position();
            default: ;
        endcase
        if (!status_set) res.status = (cur_phase == PH_IDLE) ? ST_DONE : ST_BUSY;
        res.known      = slot_known;
        res.cell_index = slot_known ? 6'(cur_slot / step) : 6'd0;
        return res;
    endfunction

    task automatic reset_positioner_state();
        cur_phase   = PH_IDLE;
        cur_slot    = '0;
        slot_known  = 1'b0;
        goal_slot   = '0;
        heading_fwd = 1'b1;
        ticks_since = '0;
        step_reg    = 7'd1;
        timeout_reg = 16'd5000;
        braking     = 1'b0;
    endtask

    task automatic send_event(t_cassette_event ev);
        t_cassette_result res;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid          <= 1'b1;
        i_op                <= ev.op;
        i_target_cell       <= ev.tgt_cell;
        i_event_code        <= ev.code;
        i_zero_sensor_level <= ev.zero_lit;
        i_cell_sensor_level <= ev.cell_lit;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = advance_positioner(ev);
        expected_results.push_back(res);
        if (res.motor == MC_DECEL) braking = 1'b1;
        else if (res.motor != MC_NONE) braking = 1'b0;
    endtask

    task automatic wait_for_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_transfer(logic idx, logic wr, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (!wr && prdata !== value) begin
            $display("%0t: register %0d read expected %0h actual %0h",
                     $time, idx, value, prdata);
            fault_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_register(logic idx, logic [31:0] value);
        logic [31:0] held;
        wait_for_idle();
        apb_transfer(idx, 1'b1, value);
        if (idx == REG_CELL_STEP) begin
            step_reg = value[STEP_W-1:0];
            held     = 32'(value[STEP_W-1:0]);
        end else begin
            timeout_reg = value[TICK_W-1:0];
            held        = 32'(value[TICK_W-1:0]);
        end
        apb_transfer(idx, 1'b0, held);
    endtask

    task automatic configure(logic [STEP_W-1:0] step, logic [TICK_W-1:0] limit);
        write_register(REG_CELL_STEP, 32'(step));
        write_register(REG_TIMEOUT, 32'(limit));
    endtask

    function automatic t_cassette_event pick_random_event();
        t_cassette_event ev;
        int roll;
        int top_cell;
        ev.op       = t_op'($urandom_range(0, 7));
        ev.tgt_cell = 6'($urandom_range(0, 63));
        ev.code     = t_evt'($urandom_range(0, 3));
        ev.zero_lit = 1'($urandom_range(0, 1));
        ev.cell_lit = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 10) return ev;
        if (roll < 18) begin
            ev.op = OP_TICK;
            return ev;
        end
        if (roll < 20) begin
            ev.op = OP_KEY;
            return ev;
        end
        if (roll < 22) begin
            ev.op = OP_FORGET;
            return ev;
        end
        top_cell = 63 / effective_step();
        if (roll < 25 || cur_phase == PH_IDLE) begin
            ev.op = OP_GOTO;
            if ($urandom_range(0, 99) < 85) ev.tgt_cell = 6'($urandom_range(0, top_cell));
            return ev;
        end
        case (cur_phase)
            PH_ZERO_ON: begin
                ev.op   = braking ? OP_STOPPED : OP_SNS_ON;
                ev.code = EV_ZERO;
            end
            PH_ZERO_OFF: begin
                ev.op   = braking ? OP_STOPPED : OP_SNS_OFF;
                ev.code = EV_ZERO;
            end
            PH_CELL_OFF: begin
                ev.op   = OP_SNS_OFF;
                ev.code = EV_CELL;
            end
            PH_CELL_ON: begin
                ev.op   = OP_SNS_ON;
                ev.code = EV_CELL;
            end
            default: ev.op = OP_STOPPED;
        endcase
        return ev;
    endfunction

    task automatic run_random_phase(logic [STEP_W-1:0] step, logic [TICK_W-1:0] limit);
        configure(step, limit);
        repeat (PHASE_EVENTS) send_event(pick_random_event());
    endtask

    task automatic test_register_access();
        configure(7'd64, 16'd0);
        configure(7'd0, 16'd65535);
        configure(7'd1, 16'd5000);
    endtask

    task automatic test_homing_and_stepping();
        send_event(cassette_event(OP_TICK, 6'd0, EV_ZERO, 1'b0, 1'b0));
        // home from a lit zero sensor: back off, then forward onto it
        send_event(cassette_event(OP_GOTO, 6'd63, EV_OTHER, 1'b1, 1'b0));
        send_event(cassette_event(OP_SNS_OFF, 6'd0, EV_ZERO, 1'b0, 1'b0));
        send_event(cassette_event(OP_STOPPED, 6'd0, EV_ZERO, 1'b0, 1'b0));
        send_event(cassette_event(OP_SNS_ON, 6'd0, EV_ZERO, 1'b1, 1'b0));
        send_event(cassette_event(OP_STOPPED, 6'd0, EV_ZERO, 1'b1, 1'b0));
        send_event(cassette_event(OP_SNS_ON, 6'd0, EV_CELL, 1'b0, 1'b1));
        send_event(cassette_event(OP_SNS_OFF, 6'd0, EV_CELL, 1'b0, 1'b0));
        send_event(cassette_event(OP_KEY, 6'd0, EV_OTHER, 1'b0, 1'b0));
        send_event(cassette_event(OP_KEY, 6'd0, EV_STOP_KEY, 1'b0, 1'b0));
        // home to slot zero from a dark sensor
        send_event(cassette_event(OP_GOTO, 6'd0, EV_ZERO, 1'b0, 1'b0));
        send_event(cassette_event(OP_SNS_ON, 6'd0, EV_ZERO, 1'b1, 1'b0));
        send_event(cassette_event(OP_STOPPED, 6'd0, EV_ZERO, 1'b1, 1'b1));
        send_event(cassette_event(OP_GOTO, 6'd0, EV_ZERO, 1'b1, 1'b1));
        // step forward two slots
        send_event(cassette_event(OP_GOTO, 6'd2, EV_CELL, 1'b0, 1'b1));
        send_event(cassette_event(OP_SNS_OFF, 6'd0, EV_CELL, 1'b0, 1'b0));
        send_event(cassette_event(OP_SNS_ON, 6'd0, EV_CELL, 1'b0, 1'b1));
        send_event(cassette_event(OP_SNS_OFF, 6'd0, EV_CELL, 1'b0, 1'b0));
        send_event(cassette_event(OP_SNS_ON, 6'd0, EV_CELL, 1'b0, 1'b1));
        send_event(cassette_event(OP_STOPPED, 6'd0, EV_CELL, 1'b0, 1'b1));
        // back one, forgetting mid-move so the count saturates at zero
        send_event(cassette_event(OP_GOTO, 6'd1, EV_CELL, 1'b0, 1'b0));
        send_event(cassette_event(OP_FORGET, 6'd0, EV_CELL, 1'b0, 1'b0));
        send_event(cassette_event(OP_SNS_ON, 6'd0, EV_CELL, 1'b0, 1'b1));
        send_event(cassette_event(OP_STOPPED, 6'd0, EV_CELL, 1'b0, 1'b1));
        send_event(cassette_event(OP_UNUSED, 6'd63, EV_OTHER, 1'b1, 1'b1));
    endtask

    task automatic test_limits_and_breaks();
        configure(7'd64, 16'd0);
        send_event(cassette_event(OP_GOTO, 6'd1, EV_ZERO, 1'b0, 1'b0));
        send_event(cassette_event(OP_GOTO, 6'd0, EV_ZERO, 1'b0, 1'b0));
        send_event(cassette_event(OP_GOTO, 6'd0, EV_ZERO, 1'b1, 1'b0));
        send_event(cassette_event(OP_TICK, 6'd0, EV_ZERO, 1'b0, 1'b0));
        configure(7'd0, 16'd65535);
        send_event(cassette_event(OP_GOTO, 6'd63, EV_ZERO, 1'b0, 1'b0));
        send_event(cassette_event(OP_TICK, 6'd0, EV_ZERO, 1'b0, 1'b0));
        send_event(cassette_event(OP_KEY, 6'd0, EV_STOP_KEY, 1'b0, 1'b0));
        configure(7'd2, 16'd2);
        send_event(cassette_event(OP_GOTO, 6'd63, EV_ZERO, 1'b0, 1'b0));
        send_event(cassette_event(OP_GOTO, 6'd5, EV_ZERO, 1'b0, 1'b0));
        send_event(cassette_event(OP_TICK, 6'd0, EV_ZERO, 1'b0, 1'b0));
        send_event(cassette_event(OP_TICK, 6'd0, EV_ZERO, 1'b0, 1'b0));
    endtask

    task automatic test_random_traffic(int gap_pct, int stall_pct,
                                       logic [STEP_W-1:0] step_a, logic [TICK_W-1:0] limit_a,
                                       logic [STEP_W-1:0] step_b, logic [TICK_W-1:0] limit_b);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        run_random_phase(step_a, limit_a);
        run_random_phase(step_b, limit_b);
    endtask

    task automatic test_backpressure();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        configure(7'd1, 16'd5000);
        // hold the output off while events keep coming
        hold_off_left = 300;
        repeat (PHASE_EVENTS) send_event(pick_random_event());
    endtask

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_op                = OP_TICK;
        i_target_cell       = '0;
        i_event_code        = EV_ZERO;
        i_zero_sensor_level = 1'b0;
        i_cell_sensor_level = 1'b0;
        i_out_stall         = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        fault_count         = 0;
        cycle_count         = 0;
        hold_off_left       = 0;
        send_gap_pct        = 16;
        recv_stall_pct      = 75;
        reset_positioner_state();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_homing_and_stepping();
        test_limits_and_breaks();
        test_random_traffic(16, 75, 7'd1, 16'd12, 7'd3, 16'd65535);
        test_random_traffic(75, 16, 7'd64, 16'd0,
                            7'($urandom_range(2, 8)), 16'($urandom_range(4, 40)));
        test_backpressure();
        test_random_traffic(0, 0, 7'd0, 16'd30, 7'd5, 16'd5000);

        wait_for_idle();
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/cpos_pkg.sv
rtl/cpos_ctrl.sv
rtl/cpos_dpath.sv
rtl/cassette_positioner_fsm.sv
test/cassette_positioner_fsm_test.sv
